@@ hw/rtl/mrpg_pkg.sv @@
// Shared widths, constants and types of the mixed rotary phase generator.
package mrpg_pkg;

  // Field widths.
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned GRID_W     = 11;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_SCALE = 2'd2;

  localparam logic [GRID_W-1:0]  GRID_RESET  = 11'd1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd12582912;

  // Internal datapath widths.
  localparam int unsigned C2_W       = IDX_W + 3;        // doubled centred position
  localparam int unsigned P_W        = C2_W + FREQ_W;    // centred position times frequency
  localparam int unsigned PT_W       = IDX_W + 1 + FREQ_W;
  localparam int unsigned SUM_W      = P_W + SCALE_W + 1;
  localparam int unsigned TERM_SHIFT = 17;
  localparam int unsigned MOD_CELLS  = 21;
  localparam int unsigned MOD_W      = 57;
  localparam int unsigned RED_W      = 36;
  localparam int unsigned RED_SHIFT  = 13;
  localparam int unsigned A_W        = RED_W - RED_SHIFT;
  localparam int unsigned XY_W       = 32;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned Q_SHIFT    = 15;

  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_ENTRIES  = 24;
  localparam int unsigned SH_W          = $clog2(CORDIC_STAGES);

  localparam longint unsigned TWO_PI_Q33_VAL = 64'd53972150818;
  localparam logic [MOD_W-1:0] TWO_PI_Q33 = MOD_W'(TWO_PI_Q33_VAL);
  // A multiple of 2*pi that makes every phase sum positive before reduction.
  localparam logic signed [SUM_W-1:0] MOD_OFFSET =
      $signed(SUM_W'(TWO_PI_Q33_VAL << (MOD_CELLS - 1)));

  localparam logic [A_W-1:0] TWO_PI_Q20  = 23'd6588397;
  localparam logic [A_W-1:0] PI_Q20      = 23'd3294199;
  localparam logic [A_W-1:0] HALF_PI_Q20 = 23'd1647099;
  localparam logic [RED_W:0] RND_Q33     = 37'd4096;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = 32'sd652032874;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'd843314857, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
    32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  typedef struct packed {
    logic [GRID_W-1:0]  grid_height;
    logic [GRID_W-1:0]  grid_width;
    logic [SCALE_W-1:0] position_scale;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         frame_index;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [FREQ_W-1:0] freq_time;
    logic signed [FREQ_W-1:0] freq_row;
    logic signed [FREQ_W-1:0] freq_col;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cosine;
    logic signed [OUT_W-1:0] sine;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [MOD_W-1:0] rem;
  } mod_tok_t;

  typedef struct packed {
    logic                   valid;
    logic                   neg;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_tok_t;

endpackage

@@ hw/rtl/mrpg_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
interface mrpg_in_if import mrpg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         frame_index;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [FREQ_W-1:0] freq_time;
  logic signed [FREQ_W-1:0] freq_row;
  logic signed [FREQ_W-1:0] freq_col;

  modport source (
    output valid, frame_index, row_index, col_index, freq_time, freq_row, freq_col,
    input  ready
  );
  modport sink (
    input  valid, frame_index, row_index, col_index, freq_time, freq_row, freq_col,
    output ready
  );
endinterface

interface mrpg_out_if import mrpg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] cosine;
  logic signed [OUT_W-1:0] sine;

  modport source (output valid, cosine, sine, input ready);
  modport sink (input valid, cosine, sine, output ready);
endinterface

@@ hw/rtl/mrpg_front.sv @@
// Front pipeline: centring, products with frequencies and scale, phase sum.
module mrpg_front import mrpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  input  in_item_t item_i,
  output mod_tok_t tok_o
);

  logic signed [C2_W-1:0]  row_c2, col_c2;
  logic signed [P_W-1:0]   prow_d, pcol_d, prow_q, pcol_q;
  logic signed [PT_W-1:0]  ptime_d, ptime_q;
  logic signed [SUM_W-1:0] qrow_d, qcol_d, tt_d, qrow_q, qcol_q, tt_q;
  logic signed [SUM_W-1:0] qs_d, qs_q, tt3_q, val_d;
  logic signed [SUM_W-1:0] scale_s;
  logic [MOD_W-1:0]        val_q;
  logic                    v1_q, v2_q, v3_q, v4_q;

  // Doubled centred positions 2*i + 1 - size, exact in C2_W bits.
  assign row_c2 = $signed({2'b00, item_i.row_index, 1'b0} + C2_W'(1)
                          - {2'b00, cfg_i.grid_height});
  assign col_c2 = $signed({2'b00, item_i.col_index, 1'b0} + C2_W'(1)
                          - {2'b00, cfg_i.grid_width});

  assign prow_d  = P_W'(row_c2) * P_W'(item_i.freq_row);
  assign pcol_d  = P_W'(col_c2) * P_W'(item_i.freq_col);
  assign ptime_d = PT_W'($signed({1'b0, item_i.frame_index})) * PT_W'(item_i.freq_time);

  assign scale_s = $signed({{(SUM_W-SCALE_W){1'b0}}, cfg_i.position_scale});
  assign qrow_d  = SUM_W'(prow_q) * scale_s;
  assign qcol_d  = SUM_W'(pcol_q) * scale_s;
  assign tt_d    = (SUM_W'(ptime_q) <<< TERM_SHIFT) + MOD_OFFSET;

  assign qs_d  = qrow_q + qcol_q;
  assign val_d = qs_q + tt3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prow_q  <= prow_d;
      pcol_q  <= pcol_d;
      ptime_q <= ptime_d;
      qrow_q  <= qrow_d;
      qcol_q  <= qcol_d;
      tt_q    <= tt_d;
      qs_q    <= qs_d;
      tt3_q   <= tt_q;
      val_q   <= val_d[MOD_W-1:0];
    end
  end

  assign tok_o.valid = v4_q;
  assign tok_o.rem   = val_q;

endmodule

@@ hw/rtl/mrpg_mod_cell.sv @@
// Reduction cell: subtracts one shifted multiple of 2*pi when it fits.
module mrpg_mod_cell import mrpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [MOD_W-1:0] modulus_i,
  input  mod_tok_t         tok_i,
  output mod_tok_t         tok_o
);

  logic             valid_q;
  logic [MOD_W-1:0] rem_d, rem_q;

  assign rem_d = (tok_i.rem >= modulus_i) ? tok_i.rem - modulus_i : tok_i.rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
    end
  end

  assign tok_o.valid = valid_q;
  assign tok_o.rem   = rem_q;

endmodule

@@ hw/rtl/mrpg_fold.sv @@
// Rounds the reduced phase to Q3.20, folds it into [-pi/2, pi/2], seeds the CORDIC.
module mrpg_fold import mrpg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  mod_tok_t    tok_i,
  output cordic_tok_t tok_o
);

  localparam logic signed [A_W:0] TWO_PI_S  = $signed({1'b0, TWO_PI_Q20});
  localparam logic signed [A_W:0] PI_S      = $signed({1'b0, PI_Q20});
  localparam logic signed [A_W:0] HALF_S    = $signed({1'b0, HALF_PI_Q20});
  localparam logic signed [Z_W-1:0] Z_HALF  = Z_W'(HALF_S) <<< 10;

  logic [RED_W:0]         rnd;
  logic [A_W-1:0]         a_raw, a_wrap;
  logic signed [A_W:0]    a_sgn, a_fold;
  logic                   neg_d, neg_q, valid_q;
  logic signed [Z_W-1:0]  z_d, z_q;

  assign rnd    = {1'b0, tok_i.rem[RED_W-1:0]} + RND_Q33;
  assign a_raw  = rnd[RED_W-1:RED_SHIFT];
  // A rounded phase equal to 2*pi wraps to zero.
  assign a_wrap = (a_raw >= TWO_PI_Q20) ? a_raw - TWO_PI_Q20 : a_raw;
  assign a_sgn  = (a_wrap >= PI_Q20) ? $signed({1'b0, a_wrap}) - TWO_PI_S
                                     : $signed({1'b0, a_wrap});

  always_comb begin
    a_fold = a_sgn;
    neg_d  = 1'b0;
    priority if (a_sgn > HALF_S) begin
      a_fold = a_sgn - PI_S;
      neg_d  = 1'b1;
    end else if (a_sgn < -HALF_S) begin
      a_fold = a_sgn + PI_S;
      neg_d  = 1'b1;
    end else begin
      a_fold = a_sgn;
    end
  end

  assign z_d = Z_W'(a_fold) <<< 10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q   <= z_d;
      neg_q <= neg_d;
    end
  end

  assign tok_o.valid = valid_q;
  assign tok_o.neg   = neg_q;
  assign tok_o.x     = GAIN_Q30;
  assign tok_o.y     = '0;
  assign tok_o.z     = z_q;

`ifndef SYNTH
  // The reduction chain must leave a remainder below 2*pi.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid |-> (tok_i.rem < TWO_PI_Q33))
    else $error("reduced phase not below 2*pi");

  // The folded angle handed to the CORDIC stays within a quarter turn.
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_o.valid |-> (tok_o.z <= Z_HALF && tok_o.z >= -Z_HALF))
    else $error("folded angle outside [-pi/2, pi/2]");
`endif

endmodule

@@ hw/rtl/mrpg_cordic_cell.sv @@
// One rotation-mode CORDIC iteration with its own pipeline register.
module mrpg_cordic_cell import mrpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [SH_W-1:0]       shift_i,
  input  logic signed [Z_W-1:0] atan_i,
  input  cordic_tok_t           tok_i,
  output cordic_tok_t           tok_o
);

  logic signed [XY_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0]  z_d, z_q;
  logic                   valid_q, neg_q;

  // Arithmetic shifts give floor division by the power of two.
  assign dx = tok_i.y >>> shift_i;
  assign dy = tok_i.x >>> shift_i;

  always_comb begin
    if (tok_i.z >= 0) begin
      x_d = tok_i.x - dx;
      y_d = tok_i.y + dy;
      z_d = tok_i.z - atan_i;
    end else begin
      x_d = tok_i.x + dx;
      y_d = tok_i.y - dy;
      z_d = tok_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      neg_q <= tok_i.neg;
    end
  end

  assign tok_o.valid = valid_q;
  assign tok_o.neg   = neg_q;
  assign tok_o.x     = x_q;
  assign tok_o.y     = y_q;
  assign tok_o.z     = z_q;

endmodule

@@ hw/rtl/mixed_rotary_phase_generator_top.sv @@
// Top level: config registers, phase pipeline, CORDIC chain and result buffer.
// Throughput: one transaction per cycle; every stage is a register in one shared pipeline.
// The pipeline stalls only while the two-entry result buffer is full.
// Reset clears all valid bits and the result buffer and restores the register defaults.
// There is no clearing pass; the block accepts input from the first cycle after reset.
module mixed_rotary_phase_generator_top import mrpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mrpg_in_if.sink               in_i,
  mrpg_out_if.source            out_o
);

  cfg_t        cfg_q;
  in_item_t    item;
  logic        en;
  mod_tok_t    mt [MOD_CELLS+1];
  cordic_tok_t ct [CORDIC_STAGES+1];
  cordic_tok_t last;
  out_item_t   res_d;
  out_item_t   mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        wr, rd;
  logic signed [XY_W:0] xv, yv;

  function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [XY_W:0] v);
    logic signed [XY_W:0] r;
    r = (v + (XY_W+1)'(16384)) >>> Q_SHIFT;
    if (r > (XY_W+1)'(32767)) begin
      r = (XY_W+1)'(32767);
    end else if (r < (XY_W+1)'(-32768)) begin
      r = (XY_W+1)'(-32768);
    end
    return r[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_height    <= GRID_RESET;
      cfg_q.grid_width     <= GRID_RESET;
      cfg_q.position_scale <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_HEIGHT:    cfg_q.grid_height    <= cfg_wdata_i[GRID_W-1:0];
        REG_GRID_WIDTH:     cfg_q.grid_width     <= cfg_wdata_i[GRID_W-1:0];
        REG_POSITION_SCALE: cfg_q.position_scale <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.frame_index = in_i.frame_index;
  assign item.row_index   = in_i.row_index;
  assign item.col_index   = in_i.col_index;
  assign item.freq_time   = in_i.freq_time;
  assign item.freq_row    = in_i.freq_row;
  assign item.freq_col    = in_i.freq_col;

  // The whole pipeline moves unless the result buffer is full.
  assign en         = (count_q != 2'd2);
  assign in_i.ready = en;

  mrpg_front u_front (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .item_i     (item),
    .tok_o      (mt[0])
  );

  for (genvar j = 0; j < MOD_CELLS; j++) begin : g_mod
    localparam logic [MOD_W-1:0] MODULUS = TWO_PI_Q33 << (MOD_CELLS - 1 - j);
    mrpg_mod_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i      (en),
      .modulus_i (MODULUS),
      .tok_i     (mt[j]),
      .tok_o     (mt[j+1])
    );
  end

  mrpg_fold u_fold (
    .clk_i,
    .rst_ni,
    .en_i  (en),
    .tok_i (mt[MOD_CELLS]),
    .tok_o (ct[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    mrpg_cordic_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .shift_i (SH_W'(i)),
      .atan_i  ($signed(Z_W'(ATAN_Q30[i]))),
      .tok_i   (ct[i]),
      .tok_o   (ct[i+1])
    );
  end

  assign last = ct[CORDIC_STAGES];
  assign xv   = last.neg ? -(XY_W+1)'(last.x) : (XY_W+1)'(last.x);
  assign yv   = last.neg ? -(XY_W+1)'(last.y) : (XY_W+1)'(last.y);
  assign res_d.cosine = to_q15(xv);
  assign res_d.sine   = to_q15(yv);

  assign wr      = en && last.valid;
  assign rd      = out_o.valid && out_o.ready;
  assign count_d = count_q + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (wr) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_o.valid  = (count_q != 2'd0);
  assign out_o.cosine = mem_q[rd_ptr_q].cosine;
  assign out_o.sine   = mem_q[rd_ptr_q].sine;

`ifndef SYNTH
  // The result buffer never holds more than two transactions.
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer overflow");

  // A read with no write frees exactly one entry.
  a_buf_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && !wr) |=> (count_q == $past(count_q) - 2'd1))
    else $error("result buffer count wrong after read");

  // While stalled, the end of the CORDIC chain holds its transaction.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ct[CORDIC_STAGES]))
    else $error("pipeline moved during a stall");
`endif

endmodule

@@ tb/mixed_rotary_phase_generator_top_tb.sv @@
// Self-checking testbench for the mixed rotary phase generator top level.
module mixed_rotary_phase_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrpg_pkg::*;

  localparam longint PHASE_WRAP_Q33    = 64'sd53972150818;
  localparam longint PHASE_WRAP_Q20    = 64'sd6588397;
  localparam longint PHASE_PI_Q20      = 64'sd3294199;
  localparam longint PHASE_HALF_PI_Q20 = 64'sd1647099;
  localparam longint ROT_GAIN_Q30      = 64'sd652032874;
  localparam int     ARCTAN_DEPTH      = 24;
  localparam longint ARCTAN_Q30 [ARCTAN_DEPTH] = '{
    843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
  };

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam int RESULT_LATENCY = 43;
  localparam int STALL_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 130;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  sink_ready = 1'b0;
  logic                  hold_results = 1'b0;

  mrpg_in_if  in_if ();
  mrpg_out_if out_if ();

  assign out_if.ready = sink_ready;

  mixed_rotary_phase_generator_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  cfg_t      cfg_model;
  out_item_t expected_rotations [$];
  int        error_count    = 0;
  int        items_sent     = 0;
  int        results_seen   = 0;
  int        settings_used  = 0;
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [OUT_W-1:0] round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  // Phase accumulation, reduction to one turn, quadrant fold and CORDIC rotation.
  function automatic out_item_t rotate_phase(input in_item_t it, input cfg_t c);
    longint    t, row, col, ft, fr, fc, h, w, scale;
    longint    sum, red, ang, x, y, z, dx, dy;
    logic      neg;
    out_item_t res;
    t     = it.frame_index;
    row   = it.row_index;
    col   = it.col_index;
    ft    = $signed(it.freq_time);
    fr    = $signed(it.freq_row);
    fc    = $signed(it.freq_col);
    h     = c.grid_height;
    w     = c.grid_width;
    scale = c.position_scale;
    sum = t * ft * 64'sd131072 + (2 * row + 1 - h) * scale * fr
        + (2 * col + 1 - w) * scale * fc;
    red = sum % PHASE_WRAP_Q33;
    if (red < 0) red = red + PHASE_WRAP_Q33;
    ang = (red + 64'sd4096) >>> 13;
    if (ang >= PHASE_WRAP_Q20) ang = ang - PHASE_WRAP_Q20;
    if (ang >= PHASE_PI_Q20) ang = ang - PHASE_WRAP_Q20;
    neg = 1'b0;
    if (ang > PHASE_HALF_PI_Q20) begin
      ang = ang - PHASE_PI_Q20;
      neg = 1'b1;
    end else if (ang < -PHASE_HALF_PI_Q20) begin
      ang = ang + PHASE_PI_Q20;
      neg = 1'b1;
    end
    z = ang * 1024;
    x = ROT_GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < ARCTAN_DEPTH; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q30[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q30[i];
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    res.cosine = round_q15(x);
    res.sine   = round_q15(y);
    return res;
  endfunction

  function automatic in_item_t rotation_input(input int t, input int r, input int c,
                                              input int ft, input int fr, input int fc);
    in_item_t it;
    it.frame_index = t[IDX_W-1:0];
    it.row_index   = r[IDX_W-1:0];
    it.col_index   = c[IDX_W-1:0];
    it.freq_time   = ft[FREQ_W-1:0];
    it.freq_row    = fr[FREQ_W-1:0];
    it.freq_col    = fc[FREQ_W-1:0];
    return it;
  endfunction

  function automatic logic [FREQ_W-1:0] random_frequency();
    logic [FREQ_W-1:0] f;
    case ($urandom_range(7))
      0:       f = 20'h7FFFF;
      1:       f = 20'h80000;
      2:       f = FREQ_W'($urandom_range(4095)) - 20'd2048;
      default: f = FREQ_W'($urandom());
    endcase
    return f;
  endfunction

  function automatic logic [IDX_W-1:0] random_index(input logic [GRID_W-1:0] size);
    logic [IDX_W-1:0] idx;
    // Most tokens sit inside the grid; the rest use any index pattern.
    if ($urandom_range(9) < 7 && size != 0 && size <= 1024)
      idx = IDX_W'($urandom_range(size - 1));
    else
      idx = IDX_W'($urandom());
    return idx;
  endfunction

  function automatic in_item_t random_rotation_input();
    in_item_t it;
    it.frame_index = IDX_W'($urandom());
    it.row_index   = random_index(cfg_model.grid_height);
    it.col_index   = random_index(cfg_model.grid_width);
    it.freq_time   = random_frequency();
    it.freq_row    = random_frequency();
    it.freq_col    = random_frequency();
    return it;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic set_idling(input int src, input int snk);
    src_idle_pct   = src;
    sink_stall_pct = snk;
  endtask

  task automatic send_rotation_input(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.frame_index <= it.frame_index;
    in_if.row_index   <= it.row_index;
    in_if.col_index   <= it.col_index;
    in_if.freq_time   <= it.freq_time;
    in_if.freq_row    <= it.freq_row;
    in_if.freq_col    <= it.freq_col;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  task automatic settle_pipeline();
    while (expected_rotations.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_GRID_HEIGHT:    cfg_model.grid_height    = data[GRID_W-1:0];
      REG_GRID_WIDTH:     cfg_model.grid_width     = data[GRID_W-1:0];
      REG_POSITION_SCALE: cfg_model.position_scale = data[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Upper data bits above the grid width are random and must be dropped.
  task automatic configure_grid(input logic [GRID_W-1:0] h, input logic [GRID_W-1:0] w,
                                input logic [SCALE_W-1:0] scale);
    program_register(REG_GRID_HEIGHT, {13'($urandom()), h});
    program_register(REG_GRID_WIDTH, {13'($urandom()), w});
    program_register(REG_POSITION_SCALE, scale);
    settings_used++;
  endtask

  task automatic test_directed_extremes();
    set_idling(0, 0);
    // Zero phase drives the cosine to +1, which must saturate.
    send_rotation_input(rotation_input(0, 0, 0, 0, 0, 0));
    send_rotation_input(rotation_input(1, 0, 0, 102944, 0, 0));
    send_rotation_input(rotation_input(1, 0, 0, 205887, 0, 0));
    send_rotation_input(rotation_input(1, 0, 0, -102944, 0, 0));
    send_rotation_input(rotation_input(1, 0, 0, 411775, 0, 0));
    send_rotation_input(rotation_input(1, 0, 0, 1, 0, 0));
    // A tiny negative phase reduces to just under a full turn and maps to a small negative angle.
    send_rotation_input(rotation_input(1, 0, 0, -1, 0, 0));
    send_rotation_input(rotation_input(1023, 0, 0, 524287, 0, 0));
    send_rotation_input(rotation_input(1023, 0, 0, -524288, 0, 0));
    send_rotation_input(rotation_input(0, 1023, 1023, 524287, 524287, 524287));
    send_rotation_input(rotation_input(0, 1023, 1023, -524288, -524288, -524288));
    send_rotation_input(rotation_input(1023, 1023, 0, 524287, -524288, 524287));
    send_rotation_input(rotation_input(1023, 1023, 1023, 524287, 524287, 524287));
    send_rotation_input(rotation_input(1023, 1023, 1023, -524288, -524288, -524288));
    send_rotation_input(rotation_input(0, 1, 0, 0, 1, 0));
    release_input();
    settle_pipeline();
  endtask

  task automatic test_zero_grid();
    configure_grid(11'd0, 11'd0, SCALE_RESET);
    send_rotation_input(rotation_input(0, 0, 0, 0, 65536, -65536));
    send_rotation_input(rotation_input(5, 1023, 1023, 1000, 524287, -524288));
    send_rotation_input(rotation_input(1023, 0, 1023, -524288, -1, 1));
    release_input();
    settle_pipeline();
  endtask

  task automatic test_unmapped_register();
    configure_grid(11'd4, 11'd6, 24'd1310720);
    program_register(REG_UNMAPPED, CFG_DATA_W'($urandom()));
    // Indices past the grid size are used as given.
    send_rotation_input(rotation_input(3, 1, 2, 70000, -30000, 12345));
    send_rotation_input(rotation_input(9, 1000, 900, -70000, 30000, -12345));
    release_input();
    settle_pipeline();
  endtask

  task automatic test_register_extremes();
    configure_grid(11'h7FF, 11'h7FF, 24'hFFFFFF);
    send_rotation_input(rotation_input(0, 0, 0, 0, 524287, -524288));
    send_rotation_input(rotation_input(1023, 1023, 1023, -524288, -524288, -524288));
    release_input();
    settle_pipeline();
    configure_grid(11'd1, 11'd1024, 24'd0);
    send_rotation_input(rotation_input(1023, 1023, 0, 524287, 524287, 524287));
    send_rotation_input(rotation_input(0, 512, 1023, 1, -524288, 524287));
    release_input();
    settle_pipeline();
  endtask

  task automatic run_random_phase(input logic [GRID_W-1:0] h, input logic [GRID_W-1:0] w,
                                  input logic [SCALE_W-1:0] scale,
                                  input int src, input int snk, input int count);
    configure_grid(h, w, scale);
    program_register(REG_UNMAPPED, CFG_DATA_W'($urandom()));
    set_idling(src, snk);
    repeat (count) send_rotation_input(random_rotation_input());
    release_input();
    settle_pipeline();
  endtask

  task automatic test_random_configs();
    run_random_phase(11'd1, 11'd1, SCALE_RESET, 0, 0, PHASE_ITEMS);
    run_random_phase(11'd32, 11'd32, 24'd393216, 47, 0, PHASE_ITEMS);
    run_random_phase(11'd1024, 11'd1024, 24'd12288, 0, 47, PHASE_ITEMS);
    run_random_phase(11'd16, 11'd64, 24'd393216, 15, 15, PHASE_ITEMS);
    run_random_phase(11'd7, 11'd5, 24'd2126779, 47, 0, PHASE_ITEMS);
    run_random_phase(11'h7FF, 11'h7FF, 24'hFFFFFF, 0, 47, PHASE_ITEMS);
    run_random_phase(GRID_W'($urandom()), GRID_W'($urandom()), SCALE_W'($urandom()),
                     15, 15, PHASE_ITEMS);
    run_random_phase(GRID_W'($urandom_range(64)), GRID_W'($urandom_range(64)),
                     SCALE_W'($urandom()), 0, 0, PHASE_ITEMS);
  endtask

  // The result side holds off long enough for the pipeline to fill and stall its input.
  task automatic test_backpressure();
    configure_grid(11'd24, 11'd40, 24'd401318);
    set_idling(0, 0);
    fork
      begin
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end
      begin
        repeat (120) send_rotation_input(random_rotation_input());
      end
    join
    release_input();
    settle_pipeline();
  endtask

  always @(negedge clk_i) begin
    sink_ready <= !hold_results && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    in_item_t accepted;
    if (rst_ni && in_if.valid && in_if.ready) begin
      accepted.frame_index = in_if.frame_index;
      accepted.row_index   = in_if.row_index;
      accepted.col_index   = in_if.col_index;
      accepted.freq_time   = in_if.freq_time;
      accepted.freq_row    = in_if.freq_row;
      accepted.freq_col    = in_if.freq_col;
      expected_rotations = {expected_rotations, rotate_phase(accepted, cfg_model)};
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_rotations.size() == 0) begin
        report_error($sformatf("unexpected result transaction: cosine %0d sine %0d",
                               out_if.cosine, out_if.sine));
      end else begin
        want = expected_rotations.pop_front();
        if (out_if.cosine !== want.cosine)
          report_error($sformatf("result %0d cosine: expected %0d, got %0d",
                                 results_seen, want.cosine, out_if.cosine));
        if (out_if.sine !== want.sine)
          report_error($sformatf("result %0d sine: expected %0d, got %0d",
                                 results_seen, want.sine, out_if.sine));
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = REG_GRID_HEIGHT;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.frame_index = '0;
    in_if.row_index   = '0;
    in_if.col_index   = '0;
    in_if.freq_time   = '0;
    in_if.freq_row    = '0;
    in_if.freq_col    = '0;
    cfg_model.grid_height    = GRID_RESET;
    cfg_model.grid_width     = GRID_RESET;
    cfg_model.position_scale = SCALE_RESET;
    settings_used = 1;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_zero_grid();
    test_unmapped_register();
    test_register_extremes();
    test_random_configs();
    test_backpressure();

    if (expected_rotations.size() != 0)
      report_error($sformatf("%0d expected results never arrived",
                             expected_rotations.size()));
    $display("Sent %0d input transactions and checked %0d result transactions %s",
             items_sent, results_seen, "under");
    $display("%0d register settings, covering zero and oversized grids, scale extremes, %s",
             settings_used, "unmapped writes and a long output hold-off.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
